[rtl/rdsaf_pkg.sv]
package rdsaf_pkg;

	// alternative-frequency list geometry
	localparam int AF_SLOTS = 25;
	localparam int AF_CW    = $clog2(AF_SLOTS + 1);
	localparam int AF_AW    = (AF_SLOTS > 1) ? $clog2(AF_SLOTS) : 1;
	// width that holds both a slot index and the fill count
	localparam int AF_IXW   = (AF_CW > 5) ? AF_CW : 5;

	// af code points
	localparam logic [7:0] AF_SKIP_CODE = 8'd250;
	localparam logic [7:0] AF_CNT_LO    = 8'd225;
	localparam logic [7:0] AF_CNT_HI    = 8'd249;
	localparam logic [7:0] AF_CNT_BASE  = 8'd224;
	localparam logic [7:0] AF_FREQ_MAX  = 8'd204;

	// ps name fill character
	localparam logic [7:0] PS_SPACE = 8'h20;

	typedef enum logic [0:0] {
		CMD_GROUP = 1'b0,
		CMD_READ  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		AF_NONE,
		AF_COUNT,
		AF_FREQ
	} af_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CODE,
		ST_SEARCH,
		ST_RDWAIT,
		ST_DONE
	} back_state_t;

	// one classified transaction as it sits in the queue
	typedef struct packed {
		cmd_t       cmd;
		logic       ta;
		logic       ms;
		logic       di;
		logic [1:0] seg;
		logic [7:0] ch_hi;
		logic [7:0] ch_lo;
		logic       ok_hi;
		logic       ok_lo;
		af_kind_t   kind_hi;
		af_kind_t   kind_lo;
		logic [7:0] code_hi;
		logic [7:0] code_lo;
		logic [4:0] idx;
	} rdsaf_item_t;

endpackage

[rtl/rdsaf_front.sv]
module rdsaf_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  cmd,
	input  logic [15:0]           block_b,
	input  logic [15:0]           block_c,
	input  logic [15:0]           block_d,
	input  logic [4:0]            entry_index,
	output logic                  q_valid,
	output rdsaf_pkg::rdsaf_item_t q_item,
	input  logic                  q_pop
);
	import rdsaf_pkg::*;

	function automatic logic ps_char_ok(input logic [7:0] c);
		logic ok;
		ok = (c == PS_SPACE)
			|| (c >= 8'h30 && c <= 8'h39)
			|| (c >= 8'h41 && c <= 8'h5a)
			|| (c >= 8'h61 && c <= 8'h7a);
		return ok;
	endfunction

	function automatic af_kind_t af_kind(input logic [7:0] code);
		af_kind_t k;
		if (code >= AF_CNT_LO && code <= AF_CNT_HI) begin
			k = AF_COUNT;
		end else if (code != 8'd0 && code <= AF_FREQ_MAX) begin
			k = AF_FREQ;
		end else begin
			k = AF_NONE;
		end
		return k;
	endfunction

	rdsaf_item_t item_d;
	rdsaf_item_t slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	logic        af_take;

	// classify the incoming transaction
	always_comb begin
		af_take        = !block_b[11] && (block_c[7:0] != AF_SKIP_CODE);
		item_d.cmd     = cmd_t'(cmd);
		item_d.ta      = block_b[4];
		item_d.ms      = block_b[3];
		item_d.di      = block_b[2];
		item_d.seg     = block_b[1:0];
		item_d.ch_hi   = block_d[15:8];
		item_d.ch_lo   = block_d[7:0];
		item_d.ok_hi   = ps_char_ok(block_d[15:8]);
		item_d.ok_lo   = ps_char_ok(block_d[7:0]);
		item_d.kind_hi = af_take ? af_kind(block_c[15:8]) : AF_NONE;
		item_d.kind_lo = af_take ? af_kind(block_c[7:0]) : AF_NONE;
		item_d.code_hi = block_c[15:8];
		item_d.code_lo = block_c[7:0];
		item_d.idx     = entry_index;
	end

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = slot_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item_d;
		end
	end

	// queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/rdsaf_back.sv]
module rdsaf_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  rdsaf_pkg::rdsaf_item_t q_item,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  traffic_announcement,
	output logic                  music,
	output logic [3:0]            decoder_id_bits,
	output logic [1:0]            segment,
	output logic [3:0]            segments_seen,
	output logic [4:0]            af_announced,
	output logic [63:0]           ps_name,
	output logic [7:0]            af_value
);
	import rdsaf_pkg::*;

	back_state_t state_q, state_d;
	rdsaf_item_t cur_q;

	// architectural state
	logic [7:0]       ps_q [8];
	logic [7:0]       af_mem [AF_SLOTS];
	logic [AF_CW-1:0] fill_q;
	logic [4:0]       af_count_q;
	logic [3:0]       di_q;
	logic [3:0]       seen_q;
	logic             ta_q;
	logic             ms_q;
	logic [1:0]       seg_q;

	// sequencing
	logic             code_sel_q;
	logic [AF_CW-1:0] i_q;
	logic             rd_valid_s1;
	logic [7:0]       rd_data_s1;
	logic [7:0]       res_afv_q;
	logic             out_valid_q;

	logic             rd_en;
	logic [AF_AW-1:0] rd_addr;
	logic             load_out;
	logic             code_adv;
	logic             append;
	logic             issuing;
	logic             hit;
	logic [7:0]       code_cur;
	af_kind_t         kind_cur;
	logic [7:0]       cnt_diff;
	logic [1:0]       di_pos;
	logic             idx_in_list;

	assign code_cur    = code_sel_q ? cur_q.code_lo : cur_q.code_hi;
	assign kind_cur    = code_sel_q ? cur_q.kind_lo : cur_q.kind_hi;
	assign issuing     = (i_q < fill_q);
	assign hit         = rd_valid_s1 && (rd_data_s1 == code_cur);
	assign cnt_diff    = code_cur - AF_CNT_BASE;
	assign di_pos      = 2'd3 - cur_q.seg;
	assign idx_in_list = (AF_IXW'(cur_q.idx) < AF_IXW'(fill_q));

	// next state and strobes
	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = '0;
		load_out = 1'b0;
		code_adv = 1'b0;
		append   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (cur_q.cmd == CMD_READ) begin
					rd_en   = 1'b1;
					rd_addr = cur_q.idx[AF_AW-1:0];
					state_d = ST_RDWAIT;
				end else begin
					state_d = ST_CODE;
				end
			end
			ST_CODE: begin
				if (kind_cur == AF_FREQ) begin
					state_d = ST_SEARCH;
				end else begin
					code_adv = 1'b1;
					state_d  = code_sel_q ? ST_DONE : ST_CODE;
				end
			end
			ST_SEARCH: begin
				if (hit) begin
					code_adv = 1'b1;
					state_d  = code_sel_q ? ST_DONE : ST_CODE;
				end else if (issuing) begin
					rd_en   = 1'b1;
					rd_addr = i_q[AF_AW-1:0];
				end else begin
					append   = 1'b1;
					code_adv = 1'b1;
					state_d  = code_sel_q ? ST_DONE : ST_CODE;
				end
			end
			ST_RDWAIT: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// af list memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (append && (fill_q < AF_CW'(AF_SLOTS))) begin
			af_mem[fill_q[AF_AW-1:0]] <= code_cur;
		end
		if (rd_en) begin
			rd_data_s1 <= af_mem[rd_addr];
		end
	end

	// current transaction and read result
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_item;
		end
		if (state_q == ST_EXEC) begin
			res_afv_q <= 8'd0;
		end else if (state_q == ST_RDWAIT) begin
			res_afv_q <= idx_in_list ? rd_data_s1 : 8'd0;
		end
	end

	// group state, list fill and search control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 8; k++) begin
				ps_q[k] <= PS_SPACE;
			end
			fill_q      <= '0;
			af_count_q  <= 5'd0;
			di_q        <= 4'd0;
			seen_q      <= 4'd0;
			ta_q        <= 1'b0;
			ms_q        <= 1'b0;
			seg_q       <= 2'd0;
			code_sel_q  <= 1'b0;
			i_q         <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == ST_SEARCH) && rd_en;
			if (state_q == ST_EXEC && cur_q.cmd == CMD_GROUP) begin
				ta_q           <= cur_q.ta;
				ms_q           <= cur_q.ms;
				di_q[di_pos]   <= cur_q.di;
				seen_q[cur_q.seg] <= 1'b1;
				seg_q          <= cur_q.seg;
				code_sel_q     <= 1'b0;
				if (cur_q.ok_hi) begin
					ps_q[{cur_q.seg, 1'b0}] <= cur_q.ch_hi;
				end
				if (cur_q.ok_lo) begin
					ps_q[{cur_q.seg, 1'b1}] <= cur_q.ch_lo;
				end
			end
			// count code clears the list
			if (state_q == ST_CODE) begin
				i_q <= '0;
				if (kind_cur == AF_COUNT) begin
					af_count_q <= cnt_diff[4:0];
					fill_q     <= '0;
				end
			end
			if (state_q == ST_SEARCH && rd_en) begin
				i_q <= i_q + AF_CW'(1);
			end
			if (append && (fill_q < AF_CW'(AF_SLOTS))) begin
				fill_q <= fill_q + AF_CW'(1);
			end
			if (code_adv && !code_sel_q) begin
				code_sel_q <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			traffic_announcement <= ta_q;
			music                <= ms_q;
			decoder_id_bits      <= di_q;
			segment              <= seg_q;
			segments_seen        <= seen_q;
			af_announced         <= af_count_q;
			af_value             <= res_afv_q;
			for (int k = 0; k < 8; k++) begin
				ps_name[63 - 8 * k -: 8] <= ps_q[k];
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

[rtl/rds_group0_ps_af_assembler_top.sv]
// rds group 0 assembler: program service name and alternative-frequency list
//
// input channel (in_valid / in_stall): one transaction per rds group 0 or
// per list read. cmd 0 takes blocks b, c and d and updates flags, di bits,
// segment mask, ps characters and, for version a, the af list. cmd 1 reads
// af slot entry_index (0 past the list) and changes nothing.
// output channel (out_valid / out_stall): one result per transaction, in
// order, reporting the state after that transaction.
// the af search reads the list memory one slot per cycle over the filled
// slots (at most 25); codes that are not frequencies skip the search.
// the back end finishes one transaction before it takes the next.
// a two-entry queue takes new transactions while the back end works or a
// result waits; in_stall rises when that queue is full.
// when the receiver stalls, the result and its fields hold until taken.
// reset clears the flags, masks, count and list and fills the ps name with
// spaces; no clearing pass is needed.
module rds_group0_ps_af_assembler_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [15:0] block_b,
	input  logic [15:0] block_c,
	input  logic [15:0] block_d,
	input  logic [4:0]  entry_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        traffic_announcement,
	output logic        music,
	output logic [3:0]  decoder_id_bits,
	output logic [1:0]  segment,
	output logic [3:0]  segments_seen,
	output logic [4:0]  af_announced,
	output logic [63:0] ps_name,
	output logic [7:0]  af_value
);
	import rdsaf_pkg::*;

	rdsaf_item_t q_item;
	logic        q_valid;
	logic        q_pop;

	// front end: classify and queue
	rdsaf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.block_b     (block_b),
		.block_c     (block_c),
		.block_d     (block_d),
		.entry_index (entry_index),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop)
	);

	// back end: state update, af search and result register
	rdsaf_back u_back (
		.clk                  (clk),
		.arst_n               (arst_n),
		.q_valid              (q_valid),
		.q_item               (q_item),
		.q_pop                (q_pop),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.traffic_announcement (traffic_announcement),
		.music                (music),
		.decoder_id_bits      (decoder_id_bits),
		.segment              (segment),
		.segments_seen        (segments_seen),
		.af_announced         (af_announced),
		.ps_name              (ps_name),
		.af_value             (af_value)
	);

endmodule

[bench/rds_group0_ps_af_assembler_top_tb.sv]
`timescale 1ns / 1ps

module rds_group0_ps_af_assembler_top_tb;
	import rdsaf_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 12;
	localparam int RANDOM_ITEMS  = 1100;
	localparam int HOLD_AT_ITEM  = 300;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_CYCLES  = 80;
	localparam int LIMIT_CYCLES  = 1000000;
	localparam int PRINT_LIMIT   = 100;
	localparam int POOL_SPAN     = 34;

	// decoder state as seen on the result ports
	typedef struct packed {
		logic        ta;
		logic        ms;
		logic [3:0]  di;
		logic [1:0]  seg;
		logic [3:0]  seen;
		logic [4:0]  announced;
		logic [63:0] ps;
		logic [7:0]  afv;
	} rds_status_t;

	// one transaction, with an optional hand-written expectation
	typedef struct packed {
		cmd_t        op;
		logic [15:0] b;
		logic [15:0] c;
		logic [15:0] d;
		logic [4:0]  idx;
		logic        typed;
		rds_status_t status;
	} group0_txn_t;

	localparam rds_status_t RESET_STATUS =
		'{1'b0, 1'b0, 4'd0, 2'd0, 4'd0, 5'd0, {8{PS_SPACE}}, 8'd0};
	// seg 3 with ta, ms and di set, count code then frequency 1, chars "Z9"
	localparam rds_status_t FIRST_GROUP =
		'{1'b1, 1'b1, 4'b0001, 2'd3, 4'b1000, 5'd1, 64'h2020_2020_2020_5A39, 8'd0};
	localparam rds_status_t FIRST_READ =
		'{1'b1, 1'b1, 4'b0001, 2'd3, 4'b1000, 5'd1, 64'h2020_2020_2020_5A39, 8'd1};

	localparam int DIRECTED_N = 21;
	localparam group0_txn_t DIRECTED_ROWS [DIRECTED_N] = '{
		// reads straight after reset, first slot and far past the list
		'{CMD_READ,  16'h0000, 16'h0000, 16'h0000, 5'd0,  1'b1, RESET_STATUS},
		'{CMD_READ,  16'h0000, 16'h0000, 16'h0000, 5'd31, 1'b1, RESET_STATUS},
		// count code in the high byte clears before the low frequency lands
		'{CMD_GROUP, 16'h001F, {AF_CNT_LO, 8'd1}, 16'h5A39, 5'd0, 1'b1, FIRST_GROUP},
		'{CMD_READ,  16'h0000, 16'h0000, 16'h0000, 5'd0,  1'b1, FIRST_READ},
		'{CMD_READ,  16'h0000, 16'h0000, 16'h0000, 5'd24, 1'b1, FIRST_GROUP},
		'{CMD_READ,  16'h0000, 16'h0000, 16'h0000, 5'd25, 1'b1, FIRST_GROUP},
		// top frequency plus a duplicate
		'{CMD_GROUP, 16'h0000, {AF_FREQ_MAX, 8'd1}, 16'h4142, 5'd0, 1'b0, '0},
		// version b leaves the list alone
		'{CMD_GROUP, 16'h0805, {8'd100, 8'd101}, 16'h617A, 5'd0, 1'b0, '0},
		// lf/mf marker skips the pair, high-bit characters rejected
		'{CMD_GROUP, 16'h0002, {8'd50, AF_SKIP_CODE}, 16'hFF80, 5'd0, 1'b0, '0},
		// zero and just above the frequency range, control and brace chars
		'{CMD_GROUP, 16'h0016, {8'd0, 8'd205}, 16'h1F7B, 5'd0, 1'b0, '0},
		'{CMD_GROUP, 16'h0008, {AF_CNT_BASE, 8'd255}, 16'h2F3A, 5'd0, 1'b0, '0},
		// unused code then the top count code
		'{CMD_GROUP, 16'h0001, {8'd251, AF_CNT_HI}, 16'h405B, 5'd0, 1'b0, '0},
		'{CMD_GROUP, 16'h0003, {8'd100, 8'd100}, 16'h607B, 5'd0, 1'b0, '0},
		'{CMD_GROUP, 16'h0000, {8'd240, 8'd7}, 16'h3020, 5'd0, 1'b0, '0},
		'{CMD_READ,  16'h0000, 16'h0000, 16'h0000, 5'd0,  1'b0, '0},
		'{CMD_READ,  16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd1,  1'b0, '0},
		'{CMD_GROUP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31, 1'b0, '0},
		'{CMD_GROUP, 16'hF7FF, 16'hFFFF, 16'h0000, 5'd0,  1'b0, '0},
		'{CMD_GROUP, 16'h0000, 16'h0000, 16'h2020, 5'd0,  1'b0, '0},
		'{CMD_READ,  16'h0000, 16'h0000, 16'h0000, 5'd31, 1'b0, '0},
		'{CMD_READ,  16'h0000, 16'h0000, 16'h0000, 5'd2,  1'b0, '0}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        cmd;
	logic [15:0] block_b;
	logic [15:0] block_c;
	logic [15:0] block_d;
	logic [4:0]  entry_index;
	logic        out_valid;
	logic        out_stall;
	logic        traffic_announcement;
	logic        music;
	logic [3:0]  decoder_id_bits;
	logic [1:0]  segment;
	logic [3:0]  segments_seen;
	logic [4:0]  af_announced;
	logic [63:0] ps_name;
	logic [7:0]  af_value;

	group0_txn_t stim_q [$];
	rds_status_t pending_status_q [$];
	int          accepted_n = 0;
	int          taken_n = 0;
	int          fail_count = 0;
	int          cycle_count = 0;
	bit          receiver_holding = 1'b0;

	// predictor copy of the decoder state
	logic [7:0]  ps_bytes [8] = '{default: PS_SPACE};
	logic [7:0]  af_slots [AF_SLOTS] = '{default: 8'd0};
	logic [4:0]  announced_cnt = '0;
	logic [3:0]  di_state = '0;
	logic [3:0]  seen_state = '0;
	logic        ta_state = 1'b0;
	logic        ms_state = 1'b0;
	logic [1:0]  seg_state = '0;

	rds_group0_ps_af_assembler_top DUT (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.cmd                 (cmd),
		.block_b             (block_b),
		.block_c             (block_c),
		.block_d             (block_d),
		.entry_index         (entry_index),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.traffic_announcement(traffic_announcement),
		.music               (music),
		.decoder_id_bits     (decoder_id_bits),
		.segment             (segment),
		.segments_seen       (segments_seen),
		.af_announced        (af_announced),
		.ps_name             (ps_name),
		.af_value            (af_value)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic flag_mismatch(string msg);
		fail_count++;
		if (fail_count <= PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// one af code: count codes reset the list, frequencies not yet listed go to the first free slot
	function automatic void af_apply(logic [7:0] code);
		if (code >= AF_CNT_LO && code <= AF_CNT_HI) begin
			announced_cnt = 5'(code - AF_CNT_BASE);
			for (int i = 0; i < AF_SLOTS; i++)
				af_slots[i] = 8'd0;
		end else if (code != 8'd0 && code <= AF_FREQ_MAX) begin
			for (int i = 0; i < AF_SLOTS; i++) begin
				if (af_slots[i] == code)
					break;
				if (af_slots[i] == 8'd0) begin
					af_slots[i] = code;
					break;
				end
			end
		end
	endfunction

	function automatic rds_status_t predict_status(logic op, logic [15:0] b, logic [15:0] c,
			logic [15:0] d, logic [4:0] idx);
		rds_status_t st;
		logic [7:0]  ch;
		st = '0;
		if (op == CMD_GROUP) begin
			ta_state = b[4];
			ms_state = b[3];
			di_state[2'd3 - b[1:0]] = b[2];
			seg_state = b[1:0];
			seen_state[b[1:0]] = 1'b1;
			if (!b[11] && c[7:0] != AF_SKIP_CODE) begin
				af_apply(c[15:8]);
				af_apply(c[7:0]);
			end
			// only letters, digits and space replace a character
			for (int k = 0; k < 2; k++) begin
				ch = (k == 0) ? d[15:8] : d[7:0];
				if (ch == PS_SPACE || (ch >= 8'h30 && ch <= 8'h39) ||
						(ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A))
					ps_bytes[{b[1:0], k[0]}] = ch;
			end
		end else if (idx < AF_SLOTS) begin
			st.afv = af_slots[idx];
		end
		st.ta = ta_state;
		st.ms = ms_state;
		st.di = di_state;
		st.seg = seg_state;
		st.seen = seen_state;
		st.announced = announced_cnt;
		for (int k = 0; k < 8; k++)
			st.ps = {st.ps[55:0], ps_bytes[k]};
		return st;
	endfunction

	function automatic void queue_txn(cmd_t op, logic [15:0] b, logic [15:0] c,
			logic [15:0] d, logic [4:0] idx);
		stim_q.push_back('{op, b, c, d, idx, 1'b0, '0});
	endfunction

	// mostly printable characters, now and then any byte
	function automatic logic [7:0] ps_char();
		case ($urandom_range(9, 0))
			0: return 8'($urandom_range(255, 0));
			1: return PS_SPACE;
			2, 3: return 8'($urandom_range(8'h39, 8'h30));
			4, 5, 6: return 8'($urandom_range(8'h5A, 8'h41));
			default: return 8'($urandom_range(8'h7A, 8'h61));
		endcase
	endfunction

	function automatic logic [4:0] read_slot();
		if ($urandom_range(3, 0) == 0)
			return 5'($urandom_range(31, 0));
		return 5'($urandom_range(AF_SLOTS - 1, 0));
	endfunction

	// one station: count code, then groups drawing from a small frequency pool
	// so that duplicates show up and the list often runs full
	function automatic void add_station_run();
		int          base;
		int          groups;
		logic [15:0] b;
		logic [7:0]  hi;
		logic [7:0]  lo;
		logic [1:0]  sg;
		base = $urandom_range(AF_FREQ_MAX - POOL_SPAN + 1, 1);
		groups = $urandom_range(28, 4);
		sg = 2'($urandom_range(3, 0));
		for (int g = 0; g < groups; g++) begin
			b = 16'($urandom);
			b[11] = ($urandom_range(19, 0) == 0);
			b[1:0] = sg;
			sg = sg + 2'd1;
			hi = 8'($urandom_range(base + POOL_SPAN - 1, base));
			lo = 8'($urandom_range(base + POOL_SPAN - 1, base));
			if (g == 0)
				hi = 8'($urandom_range(AF_CNT_HI, AF_CNT_LO));
			else if ($urandom_range(19, 0) == 0)
				lo = AF_SKIP_CODE;
			queue_txn(CMD_GROUP, b, {hi, lo}, {ps_char(), ps_char()}, 5'($urandom));
			if ($urandom_range(2, 0) == 0)
				queue_txn(CMD_READ, 16'($urandom), 16'($urandom), 16'($urandom), read_slot());
		end
	endfunction

	// arbitrary transactions
	function automatic void add_noise();
		int n;
		n = $urandom_range(6, 1);
		repeat (n)
			queue_txn(cmd_t'($urandom_range(1, 0)), 16'($urandom), 16'($urandom),
				16'($urandom), 5'($urandom));
	endfunction

	// stimulus, reset, sender and end of run
	initial begin : sender
		int          burst_left;
		int          gap;
		group0_txn_t txn;
		burst_left = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		cmd <= CMD_GROUP;
		block_b <= '0;
		block_c <= '0;
		block_d <= '0;
		entry_index <= '0;

		foreach (DIRECTED_ROWS[i])
			stim_q.push_back(DIRECTED_ROWS[i]);
		while (stim_q.size() < DIRECTED_N + RANDOM_ITEMS) begin
			if ($urandom_range(99, 0) < 70)
				add_station_run();
			else
				add_noise();
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int n = 0; n < stim_q.size(); n++) begin
			// bursts of random length, gaps between them unless the receiver holds off
			if (burst_left == 0) begin
				burst_left = $urandom_range(40, 1);
				gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
				if (gap != 0 && !receiver_holding) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
			txn = stim_q[n];
			in_valid <= 1'b1;
			cmd <= txn.op;
			block_b <= txn.b;
			block_c <= txn.c;
			block_d <= txn.d;
			entry_index <= txn.idx;
			@(posedge clk);
			while (in_stall)
				@(posedge clk);
		end
		in_valid <= 1'b0;

		while (pending_status_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// receiver stall pattern, with one long hold-off to fill the block
	initial begin : receiver
		int phase_left;
		int stall_pct;
		bit hold_done;
		phase_left = 0;
		stall_pct = 0;
		hold_done = 1'b0;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!hold_done && accepted_n >= HOLD_AT_ITEM) begin
				hold_done = 1'b1;
				receiver_holding = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				receiver_holding = 1'b0;
			end else begin
				if (phase_left == 0) begin
					phase_left = $urandom_range(80, 10);
					case ($urandom_range(3, 0))
						0: stall_pct = 0;
						1: stall_pct = 20;
						2: stall_pct = 50;
						default: stall_pct = 85;
					endcase
				end
				phase_left--;
				out_stall <= ($urandom_range(99, 0) < stall_pct);
			end
		end
	end

	// predict on every accepted transaction, check every delivered result
	always @(posedge clk) begin : monitor
		rds_status_t st;
		rds_status_t got;
		rds_status_t want;
		if (arst_n === 1'b1 && in_valid && !in_stall) begin
			st = predict_status(cmd, block_b, block_c, block_d, entry_index);
			if (stim_q[accepted_n].typed)
				st = stim_q[accepted_n].status;
			pending_status_q.push_back(st);
			accepted_n++;
		end
		if (arst_n === 1'b1 && out_valid === 1'b1 && !out_stall) begin
			got = '{traffic_announcement, music, decoder_id_bits, segment, segments_seen,
				af_announced, ps_name, af_value};
			if (pending_status_q.size() == 0) begin
				flag_mismatch($sformatf("result %0d arrived with nothing expected", taken_n));
			end else begin
				want = pending_status_q.pop_front();
				if (got.ta !== want.ta)
					flag_mismatch($sformatf("result %0d traffic_announcement %0d, expected %0d",
						taken_n, got.ta, want.ta));
				if (got.ms !== want.ms)
					flag_mismatch($sformatf("result %0d music %0d, expected %0d",
						taken_n, got.ms, want.ms));
				if (got.di !== want.di)
					flag_mismatch($sformatf("result %0d decoder_id_bits %b, expected %b",
						taken_n, got.di, want.di));
				if (got.seg !== want.seg)
					flag_mismatch($sformatf("result %0d segment %0d, expected %0d",
						taken_n, got.seg, want.seg));
				if (got.seen !== want.seen)
					flag_mismatch($sformatf("result %0d segments_seen %b, expected %b",
						taken_n, got.seen, want.seen));
				if (got.announced !== want.announced)
					flag_mismatch($sformatf("result %0d af_announced %0d, expected %0d",
						taken_n, got.announced, want.announced));
				if (got.ps !== want.ps)
					flag_mismatch($sformatf("result %0d ps_name %h, expected %h",
						taken_n, got.ps, want.ps));
				if (got.afv !== want.afv)
					flag_mismatch($sformatf("result %0d af_value %0d, expected %0d",
						taken_n, got.afv, want.afv));
			end
			taken_n++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule
